// File: rtl/core/rnmb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rnmb_pkg
// shared widths, configuration codes, result type and dimension helper for
// the rgb neighbour mean blur
// ----------------------------------------------------------------------------
package rnmb_pkg;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int POS_W      = 11;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;
  // wide enough for the largest supported dimension
  localparam int DIM_W      = 14;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = CFG_DATA_W'(640);
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = CFG_DATA_W'(480);

  typedef logic [CH_W-1:0] chan_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    chan_t            red;
    chan_t            green;
    chan_t            blue;
    logic             last;
  } res_t;

  // last valid index of a dimension: zero counts as one, oversize saturates
  function automatic logic [DIM_W-1:0] last_index(input logic [CFG_DATA_W-1:0] v,
                                                  input logic [DIM_W-1:0]      maxv);
    logic [DIM_W-1:0] e;
    if (v == '0) begin
      e = DIM_W'(1);
    end else if (DIM_W'(v) > maxv) begin
      e = maxv;
    end else begin
      e = DIM_W'(v);
    end
    return e - DIM_W'(1);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/rnmb_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rnmb_if
// valid/ready channels for incoming pixels and outgoing result pixels
// ----------------------------------------------------------------------------
interface rnmb_pix_if;
  logic                 valid;
  logic                 ready;
  logic [rnmb_pkg::CH_W-1:0] red_in;
  logic [rnmb_pkg::CH_W-1:0] green_in;
  logic [rnmb_pkg::CH_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                output ready);
endinterface

interface rnmb_res_if;
  logic                       valid;
  logic                       ready;
  logic [rnmb_pkg::POS_W-1:0] out_row;
  logic [rnmb_pkg::POS_W-1:0] out_col;
  logic [rnmb_pkg::CH_W-1:0]  red_out;
  logic [rnmb_pkg::CH_W-1:0]  green_out;
  logic [rnmb_pkg::CH_W-1:0]  blue_out;
  logic                       frame_last;

  modport source (output valid, output out_row, output out_col, output red_out,
                  output green_out, output blue_out, output frame_last, input ready);
  modport sink (input valid, input out_row, input out_col, input red_out,
                input green_out, input blue_out, input frame_last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/rgb_neighbour_mean_blur.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_neighbour_mean_blur
// streaming 3x3 neighbour mean of an rgb frame, center pixel excluded
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one transaction per pixel, and the block takes
// one pixel per clock while the result queue has room. Each interior pixel
// leaves as, per channel, the sum of its eight neighbours each shifted right
// by three; border pixels leave unchanged. Every result carries its row and
// column, and the final result of a frame has frame_last set. The result for
// a pixel is produced once its lower-right neighbour (in the last column, the
// one below) has arrived, and last-row pixels as they arrive, so a pixel
// yields zero to three results. The two previous rows sit in one MAX_WIDTH x
// 48 bit line memory (upper and middle row side by side), read at the input
// transaction and written back when the pixel leaves the compute stage; with
// a frame width of one the read is forwarded from that write. A four-entry
// result queue sits in front of the output channel. Results leave at one per
// clock while the output is ready, so the sustained rate is one pixel per
// clock except in the last row of a frame, where each pixel past the first
// column gives two results, and the final pixel, which gives three. A result
// passes the compute stage register and the result queue on its way out.
// Writing either configuration register restarts the frame at row 0, column
// 0; write only while idle. Line memory needs no clearing after reset: a frame
// never uses data from an entry it has not written.
// ----------------------------------------------------------------------------
module rgb_neighbour_mean_blur #(
  parameter int MAX_WIDTH  = rnmb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rnmb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rnmb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rnmb_pkg::CFG_DATA_W-1:0] cfg_data,
  rnmb_pix_if.sink                        in_pix,
  rnmb_res_if.source                      out_res
);

  localparam int CW     = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int PIX_W  = rnmb_pkg::PIX_W;
  localparam int CH_W   = rnmb_pkg::CH_W;
  localparam int POS_W  = rnmb_pkg::POS_W;
  localparam int DIM_W  = rnmb_pkg::DIM_W;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // compute stage contents, captured at the input transaction
  typedef struct packed {
    logic [RW-1:0]    row;
    logic [CW-1:0]    col;
    logic [PIX_W-1:0] pix;
    logic             row_ge1;
    logic             row_ge2;
    logic             col_ge1;
    logic             col_ge2;
    logic             col_last;
    logic             row_last;
  } s1_t;

  // per channel sum of eight neighbours, each divided by eight
  function automatic logic [PIX_W-1:0] blur8(input logic [7:0][PIX_W-1:0] nb);
    logic [PIX_W-1:0] res;
    logic [CH_W-1:0]  s;
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      s = '0;
      for (int i = 0; i < 8; i++) begin
        s = s + CH_W'(nb[i][ch*CH_W +: CH_W] >> 3);
      end
      res[ch*CH_W +: CH_W] = s;
    end
    return res;
  endfunction

  // frame geometry and raster position of the next pixel
  logic [CW-1:0] col_last_r;
  logic [RW-1:0] row_last_r;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  // handshakes
  logic in_acc;
  logic s1_fire;
  logic q_pop;

  // compute stage
  logic s1_valid_r;
  s1_t  s1_r, s1_nxt;

  // line memory: {upper row, middle row} per column
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_r;
  logic               fwd_r;
  logic [2*PIX_W-1:0] fwd_data_r;
  logic [2*PIX_W-1:0] entry;
  logic [2*PIX_W-1:0] wr_data;
  logic [PIX_W-1:0]   up_c;
  logic [PIX_W-1:0]   mid_c;

  // two previous columns of the three rows
  logic [PIX_W-1:0] win_r [6];

  // results of the item in the compute stage
  rnmb_pkg::res_t res_a, res_b, res_c;
  logic           en_a, en_b, en_c;
  logic [1:0]     n_res;
  logic [PIX_W-1:0] px_a;
  logic [7:0][PIX_W-1:0] nb;

  // result queue
  rnmb_pkg::res_t     q_r [QDEPTH];
  logic [QPTR_W-1:0]  head_r, head_nxt;
  logic [QPTR_W-1:0]  tail_r, tail_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [QPTR_W-1:0]  off_b, off_c;
  logic [QCNT_W:0]    fill_after;
  logic               room;

  assign in_acc = in_pix.valid && in_pix.ready;
  assign q_pop  = out_res.valid && out_res.ready;

  // stage takes a new pixel when it is empty or when its current one moves on
  assign in_pix.ready = !s1_valid_r || s1_fire;

  // ---------------------------------------------------------------------------
  // configuration and raster counters
  // ---------------------------------------------------------------------------
  always_comb begin
    if (col_r == col_last_r) begin
      col_nxt = '0;
      row_nxt = (row_r == row_last_r) ? '0 : row_r + RW'(1);
    end else begin
      col_nxt = col_r + CW'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_last_r <= CW'(rnmb_pkg::last_index(rnmb_pkg::FRAME_WIDTH_RST, DIM_W'(MAX_WIDTH)));
      row_last_r <= RW'(rnmb_pkg::last_index(rnmb_pkg::FRAME_HEIGHT_RST,
                                             DIM_W'(MAX_HEIGHT)));
      col_r      <= '0;
      row_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rnmb_pkg::CFG_FRAME_WIDTH: begin
          col_last_r <= CW'(rnmb_pkg::last_index(cfg_data, DIM_W'(MAX_WIDTH)));
          col_r      <= '0;
          row_r      <= '0;
        end
        rnmb_pkg::CFG_FRAME_HEIGHT: begin
          row_last_r <= RW'(rnmb_pkg::last_index(cfg_data, DIM_W'(MAX_HEIGHT)));
          col_r      <= '0;
          row_r      <= '0;
        end
        default: begin
          // unknown index, ignored
        end
      endcase
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // compute stage capture
  // ---------------------------------------------------------------------------
  always_comb begin
    s1_nxt.row      = row_r;
    s1_nxt.col      = col_r;
    s1_nxt.pix      = {in_pix.red_in, in_pix.green_in, in_pix.blue_in};
    s1_nxt.row_ge1  = (row_r != '0);
    s1_nxt.row_ge2  = (row_r != '0) && (row_r != RW'(1));
    s1_nxt.col_ge1  = (col_r != '0);
    s1_nxt.col_ge2  = (col_r != '0) && (col_r != CW'(1));
    s1_nxt.col_last = (col_r == col_last_r);
    s1_nxt.row_last = (row_r == row_last_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        // same column written on this edge: memory read returns stale data
        fwd_r      <= s1_fire && (col_r == s1_r.col);
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
        fwd_r      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r       <= s1_nxt;
      fwd_data_r <= wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // line memory: read at the transaction, write back when the stage fires
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_r <= line_mem[col_r];
    end
    if (s1_fire) begin
      line_mem[s1_r.col] <= wr_data;
    end
  end

  assign entry   = fwd_r ? fwd_data_r : rd_r;
  assign up_c    = entry[2*PIX_W-1:PIX_W];
  assign mid_c   = entry[PIX_W-1:0];
  // middle row moves up, current pixel becomes the middle row
  assign wr_data = {mid_c, s1_r.pix};

  // ---------------------------------------------------------------------------
  // window shift
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_fire) begin
      win_r[1] <= win_r[0];
      win_r[0] <= up_c;
      win_r[3] <= win_r[2];
      win_r[2] <= mid_c;
      win_r[5] <= win_r[4];
      win_r[4] <= s1_r.pix;
    end
  end

  // ---------------------------------------------------------------------------
  // results: upper-left neighbour, upper neighbour at row end, last-row pixel
  // ---------------------------------------------------------------------------
  always_comb begin
    nb[0] = win_r[1];
    nb[1] = win_r[0];
    nb[2] = up_c;
    nb[3] = win_r[3];
    nb[4] = mid_c;
    nb[5] = win_r[5];
    nb[6] = win_r[4];
    nb[7] = s1_r.pix;
    // interior only once two rows and two columns lie behind
    px_a  = (s1_r.row_ge2 && s1_r.col_ge2) ? blur8(nb) : win_r[2];

    en_a = s1_r.row_ge1 && s1_r.col_ge1;
    en_b = s1_r.row_ge1 && s1_r.col_last;
    en_c = s1_r.row_last;
    n_res = 2'(en_a) + 2'(en_b) + 2'(en_c);

    res_a.row   = POS_W'(s1_r.row - RW'(1));
    res_a.col   = POS_W'(s1_r.col - CW'(1));
    res_a.red   = px_a[3*CH_W-1:2*CH_W];
    res_a.green = px_a[2*CH_W-1:CH_W];
    res_a.blue  = px_a[CH_W-1:0];
    res_a.last  = 1'b0;

    res_b.row   = POS_W'(s1_r.row - RW'(1));
    res_b.col   = POS_W'(s1_r.col);
    res_b.red   = mid_c[3*CH_W-1:2*CH_W];
    res_b.green = mid_c[2*CH_W-1:CH_W];
    res_b.blue  = mid_c[CH_W-1:0];
    res_b.last  = 1'b0;

    res_c.row   = POS_W'(s1_r.row);
    res_c.col   = POS_W'(s1_r.col);
    res_c.red   = s1_r.pix[3*CH_W-1:2*CH_W];
    res_c.green = s1_r.pix[2*CH_W-1:CH_W];
    res_c.blue  = s1_r.pix[CH_W-1:0];
    res_c.last  = s1_r.col_last;
  end

  // ---------------------------------------------------------------------------
  // result queue: up to three pushes, one pop per clock
  // ---------------------------------------------------------------------------
  assign fill_after = (QCNT_W+1)'(cnt_r) + (QCNT_W+1)'(n_res) - (QCNT_W+1)'(q_pop);
  assign room       = (fill_after <= (QCNT_W+1)'(QDEPTH));
  assign s1_fire    = s1_valid_r && room;

  assign off_b = tail_r + QPTR_W'(en_a);
  assign off_c = tail_r + QPTR_W'(en_a) + QPTR_W'(en_b);

  always_comb begin
    tail_nxt = tail_r;
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    if (s1_fire) begin
      tail_nxt = tail_r + QPTR_W'(n_res);
      cnt_nxt  = QCNT_W'(fill_after);
    end else if (q_pop) begin
      cnt_nxt  = cnt_r - QCNT_W'(1);
    end
    if (q_pop) begin
      head_nxt = head_r + QPTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && en_a) begin
      q_r[tail_r] <= res_a;
    end
    if (s1_fire && en_b) begin
      q_r[off_b] <= res_b;
    end
    if (s1_fire && en_c) begin
      q_r[off_c] <= res_c;
    end
  end

  assign out_res.valid      = (cnt_r != '0);
  assign out_res.out_row    = q_r[head_r].row;
  assign out_res.out_col    = q_r[head_r].col;
  assign out_res.red_out    = q_r[head_r].red;
  assign out_res.green_out  = q_r[head_r].green;
  assign out_res.blue_out   = q_r[head_r].blue;
  assign out_res.frame_last = q_r[head_r].last;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue overfilled");

  a_raster_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= col_last_r) && (row_r <= row_last_r))
    else $error("raster position outside frame");

  a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_valid_r)
    else $error("forwarded line data without an item in the stage");

  a_raster_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !cfg_we) |=> ((col_r == '0) || (col_r == $past(col_r) + CW'(1))))
    else $error("column counter skipped");

endmodule
`default_nettype wire
